// ===== sv/sgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_pkg - shared types and constants of the stereo gain mixer
// Widths, register indexes and the lane product bundle used by the lanes,
// the merge stage and the top level.
// ----------------------------------------------------------------------------
package sgm_pkg;

    // source and sample geometry
    localparam int MAX_SOURCES  = 4;
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 16;
    localparam int MASK_W       = MAX_SOURCES;
    localparam int GAIN_SEL_W   = $clog2(MAX_SOURCES);
    localparam int FRAC_BITS    = 12;
    localparam int CLIP_W       = 2;

    // signed sample times unsigned gain fits in 32 bits, four of them in 34
    localparam int PROD_W       = SAMPLE_W + GAIN_W;
    localparam int SUM_W        = PROD_W + GAIN_SEL_W;
    localparam int SCALED_W     = SUM_W - FRAC_BITS;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(4096);

    // stream payload widths, padded to whole bytes
    localparam int S_RAW_W      = 2 * MAX_SOURCES * SAMPLE_W + MASK_W;
    localparam int S_TDATA_W    = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W      = 2 * SAMPLE_W + CLIP_W;
    localparam int M_TDATA_W    = ((M_RAW_W + 7) / 8) * 8;

    // configuration register map
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = GAIN_W;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN0  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN1  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN2  = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN3  = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = CFG_ADDR_W'(4);

    // clipped flag bits
    localparam int CLIP_RIGHT   = 0;
    localparam int CLIP_LEFT    = 1;

    // weighted right/left pair from one lane
    typedef struct packed {
        logic signed [PROD_W-1:0] right;
        logic signed [PROD_W-1:0] left;
    } t_lane_prod;

endpackage

// ===== sv/stereo_gain_mixer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_gain_mixer_unit - four-source stereo mixer with per-source gain
// An input beat passes the lane multiply register, then the merge/saturate
// output register, on its way to its result beat.
// Throughput: one frame position per cycle; the output register advances
// whenever it is empty or being taken, so only downstream stalls hold input.
// Reset (synchronous, active low): gains return to unity, enable mask to 0,
// pipeline emptied.
// ----------------------------------------------------------------------------
module stereo_gain_mixer_unit
    import sgm_pkg::*;
#(
    parameter int SOURCE_COUNT = MAX_SOURCES
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // right_in0, left_in0, right_in1, left_in1, right_in2, left_in2,
    // right_in3, left_in3, source_present, zero pad
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // right_out, left_out, clipped, zero pad
    output logic [M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int MASK_LSB = 2 * MAX_SOURCES * SAMPLE_W;

    logic [GAIN_W-1:0]          r_gain [MAX_SOURCES];
    logic [MASK_W-1:0]          r_enable;
    logic                       r_s1_valid;
    logic                       n_s1_valid;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic signed [SAMPLE_W-1:0] r_right;
    logic signed [SAMPLE_W-1:0] r_left;
    logic [CLIP_W-1:0]          r_clipped;

    logic                       w_out_adv;
    logic                       w_s1_adv;
    logic                       w_accept;
    logic [MASK_W-1:0]          w_active;
    t_lane_prod                 w_prod [SOURCE_COUNT];
    logic signed [SAMPLE_W-1:0] w_right;
    logic signed [SAMPLE_W-1:0] w_left;
    logic [CLIP_W-1:0]          w_clipped;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SOURCES; k++) begin
                r_gain[k] <= GAIN_UNITY;
            end
            r_enable <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr) inside
                REG_GAIN0, REG_GAIN1, REG_GAIN2, REG_GAIN3: begin
                    r_gain[i_cfg_addr[GAIN_SEL_W-1:0]] <= i_cfg_data;
                end
                REG_ENABLE: begin
                    r_enable <= i_cfg_data[MASK_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // pipeline advance: each stage moves when the next one can take it
    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_s1_adv      = !r_s1_valid || w_out_adv;
    assign w_accept      = s_axis_tvalid && w_s1_adv;
    assign s_axis_tready = w_s1_adv;

    assign n_s1_valid  = w_s1_adv ? s_axis_tvalid : r_s1_valid;
    assign n_out_valid = w_out_adv ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // sources that are present and enabled
    assign w_active = s_axis_tdata[MASK_LSB +: MASK_W] & r_enable;

    // one multiply lane per source
    for (genvar k = 0; k < SOURCE_COUNT; k++) begin : g_lane
        sgm_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_accept),
            .i_active (w_active[k]),
            .i_right  (s_axis_tdata[2*k*SAMPLE_W +: SAMPLE_W]),
            .i_left   (s_axis_tdata[(2*k+1)*SAMPLE_W +: SAMPLE_W]),
            .i_gain   (r_gain[k]),
            .o_prod   (w_prod[k])
        );
    end

    // sum, scale, saturate
    sgm_merge #(
        .SOURCE_COUNT (SOURCE_COUNT)
    ) u_merge (
        .i_prod    (w_prod),
        .o_right   (w_right),
        .o_left    (w_left),
        .o_clipped (w_clipped)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_s1_valid) begin
            r_right   <= w_right;
            r_left    <= w_left;
            r_clipped <= w_clipped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - M_RAW_W)'(0), r_clipped, r_left, r_right};

endmodule

// ===== sv/sgm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_lane - gain multiply for one source
// Multiplies the right and left sample by the source gain and registers the
// products; an inactive source contributes zero.
// ----------------------------------------------------------------------------
module sgm_lane
    import sgm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_active,
    input  logic signed [SAMPLE_W-1:0] i_right,
    input  logic signed [SAMPLE_W-1:0] i_left,
    input  logic        [GAIN_W-1:0]   i_gain,
    output t_lane_prod                 o_prod
);

    logic signed [GAIN_W:0]   w_gain;
    logic signed [PROD_W:0]   w_prod_r;
    logic signed [PROD_W:0]   w_prod_l;
    t_lane_prod               n_prod;
    t_lane_prod               r_prod;

    // gain is unsigned: widen with a zero sign bit
    assign w_gain   = $signed({1'b0, i_gain});
    assign w_prod_r = i_right * w_gain;
    assign w_prod_l = i_left * w_gain;

    // product range stays inside PROD_W signed bits
    always_comb begin
        n_prod.right = i_active ? w_prod_r[PROD_W-1:0] : '0;
        n_prod.left  = i_active ? w_prod_l[PROD_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/sgm_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_merge - lane sum, Q12 scale-down and saturation
// Adds the lane products per channel, floors by 2^FRAC_BITS and clamps to
// signed 16 bits, flagging each channel that was clamped.
// ----------------------------------------------------------------------------
module sgm_merge
    import sgm_pkg::*;
#(
    parameter int SOURCE_COUNT = MAX_SOURCES
)
(
    input  t_lane_prod                 i_prod [SOURCE_COUNT],
    output logic signed [SAMPLE_W-1:0] o_right,
    output logic signed [SAMPLE_W-1:0] o_left,
    output logic        [CLIP_W-1:0]   o_clipped
);

    localparam logic signed [SCALED_W-1:0] SAT_MAX = SCALED_W'(32767);
    localparam logic signed [SCALED_W-1:0] SAT_MIN = -SCALED_W'(32768);

    logic signed [SUM_W-1:0]    w_sum_r;
    logic signed [SUM_W-1:0]    w_sum_l;
    logic signed [SCALED_W-1:0] w_q_r;
    logic signed [SCALED_W-1:0] w_q_l;

    // channel sums across the lanes
    always_comb begin
        w_sum_r = '0;
        w_sum_l = '0;
        for (int k = 0; k < SOURCE_COUNT; k++) begin
            w_sum_r = w_sum_r + SUM_W'(i_prod[k].right);
            w_sum_l = w_sum_l + SUM_W'(i_prod[k].left);
        end
    end

    // arithmetic shift: drop the fraction bits
    assign w_q_r = w_sum_r[SUM_W-1:FRAC_BITS];
    assign w_q_l = w_sum_l[SUM_W-1:FRAC_BITS];

    // clamp right
    always_comb begin
        o_clipped = '0;
        if (w_q_r > SAT_MAX) begin
            o_right               = SAT_MAX[SAMPLE_W-1:0];
            o_clipped[CLIP_RIGHT] = 1'b1;
        end else if (w_q_r < SAT_MIN) begin
            o_right               = SAT_MIN[SAMPLE_W-1:0];
            o_clipped[CLIP_RIGHT] = 1'b1;
        end else begin
            o_right               = w_q_r[SAMPLE_W-1:0];
        end
        // clamp left
        if (w_q_l > SAT_MAX) begin
            o_left                = SAT_MAX[SAMPLE_W-1:0];
            o_clipped[CLIP_LEFT]  = 1'b1;
        end else if (w_q_l < SAT_MIN) begin
            o_left                = SAT_MIN[SAMPLE_W-1:0];
            o_clipped[CLIP_LEFT]  = 1'b1;
        end else begin
            o_left                = w_q_l[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== sv/sgm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_checker - port-level checks for the stereo gain mixer
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module sgm_checker
    import sgm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TDATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // a result appears only for an input beat that passed the lane and output registers
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result beat without a matching input beat");

    // right clip flag means right sample sits at a rail
    a_clip_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2*SAMPLE_W + CLIP_RIGHT]) |->
        (m_axis_tdata[SAMPLE_W-1:0] == 16'h7fff || m_axis_tdata[SAMPLE_W-1:0] == 16'h8000))
        else $error("right clip flag without a saturated sample");

    // left clip flag means left sample sits at a rail
    a_clip_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2*SAMPLE_W + CLIP_LEFT]) |->
        (m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] == 16'h7fff ||
         m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] == 16'h8000))
        else $error("left clip flag without a saturated sample");

endmodule

bind stereo_gain_mixer_unit sgm_checker u_sgm_checker (.*);

// ===== tb/sv/stereo_gain_mixer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_gain_mixer_unit_test - self-checking bench for the stereo gain mixer
// Streams stereo frame positions through the mixer under several gain and
// enable settings, predicts every mixed beat from its own model of the gain,
// floor shift and saturation, and checks each output beat field by field.
// ----------------------------------------------------------------------------
module stereo_gain_mixer_unit_test;
    import sgm_pkg::*;

    localparam int LANES        = MAX_SOURCES;
    localparam int SAMPLES_W    = 2 * MAX_SOURCES * SAMPLE_W;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 235;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    // receiver hold-off and the stretch without any idling
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int BUSY_FIRST   = 800;
    localparam int BUSY_LAST    = 1100;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic {
        OP_BEAT,
        OP_CFG
    } t_op_kind;

    typedef struct {
        t_op_kind               kind;
        logic [S_TDATA_W-1:0]   beat;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_DATA_W-1:0]  wdata;
    } t_stim_op;

    // output beat layout, lowest field last
    typedef struct packed {
        logic [CLIP_W-1:0]   clipped;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_mix_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    t_stim_op               pending[$];
    t_mix_result            expected_mix[$];
    logic [GAIN_W-1:0]      gain_copy [MAX_SOURCES];
    logic [MASK_W-1:0]      enable_copy;
    int                     beats_sent    = 0;
    int                     mixes_seen    = 0;
    int                     mismatch_count = 0;
    int                     idle_cycles   = 0;
    int                     hold_left     = 0;
    bit                     hold_done     = 1'b0;

    stereo_gain_mixer_unit #(
        .SOURCE_COUNT (LANES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor shift by the fraction bits, then clamp to 16 bits; MSB flags a clip
    function automatic logic [SAMPLE_W:0] scale_clip(input longint acc);
        longint q;
        q = acc >>> FRAC_BITS;
        if (q > longint'(SAMPLE_MAX))
            return {1'b1, SAMPLE_MAX};
        if (q < longint'(SAMPLE_MIN))
            return {1'b1, SAMPLE_MIN};
        return {1'b0, q[SAMPLE_W-1:0]};
    endfunction

    // expected mix of one accepted input beat under the current settings
    function automatic t_mix_result mix_frame(input logic [S_TDATA_W-1:0] beat);
        longint            sum_r;
        longint            sum_l;
        logic [MASK_W-1:0] active;
        logic [SAMPLE_W:0] r_sat;
        logic [SAMPLE_W:0] l_sat;
        t_mix_result       res;
        sum_r  = 0;
        sum_l  = 0;
        active = beat[SAMPLES_W +: MASK_W] & enable_copy;
        for (int k = 0; k < MAX_SOURCES && k < LANES; k++) begin
            if (active[k]) begin
                sum_r += longint'($signed(beat[2*k*SAMPLE_W +: SAMPLE_W]))
                         * longint'(gain_copy[k]);
                sum_l += longint'($signed(beat[(2*k+1)*SAMPLE_W +: SAMPLE_W]))
                         * longint'(gain_copy[k]);
            end
        end
        r_sat = scale_clip(sum_r);
        l_sat = scale_clip(sum_l);
        res.right              = r_sat[SAMPLE_W-1:0];
        res.left               = l_sat[SAMPLE_W-1:0];
        res.clipped            = '0;
        res.clipped[CLIP_RIGHT] = r_sat[SAMPLE_W];
        res.clipped[CLIP_LEFT]  = l_sat[SAMPLE_W];
        return res;
    endfunction

    // samples packed right0, left0, right1 ... left3 from the lowest bit up
    task automatic queue_frame(input logic [SAMPLES_W-1:0] samples,
                               input logic [MASK_W-1:0] present);
        t_stim_op op;
        op.kind  = OP_BEAT;
        op.beat  = '0;
        op.beat[SAMPLES_W-1:0]        = samples;
        op.beat[SAMPLES_W +: MASK_W]  = present;
        op.addr  = '0;
        op.wdata = '0;
        pending.push_back(op);
    endtask

    task automatic queue_cfg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] wdata);
        t_stim_op op;
        op.kind  = OP_CFG;
        op.beat  = '0;
        op.addr  = addr;
        op.wdata = wdata;
        pending.push_back(op);
    endtask

    task automatic queue_gains(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                               input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3);
        queue_cfg(REG_GAIN0, g0);
        queue_cfg(REG_GAIN1, g1);
        queue_cfg(REG_GAIN2, g2);
        queue_cfg(REG_GAIN3, g3);
    endtask

    // extremes and near-zero values show up far more often than uniform picks would
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return '1;
            4:       return SAMPLE_W'($urandom_range(0, 127)) - SAMPLE_W'(64);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_UNITY;
            3:       return GAIN_W'($urandom_range(0, 255));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // stimulus, reset and end of run
    initial begin : stimulus
        logic [SAMPLES_W-1:0] samples;
        logic [MASK_W-1:0]    present;

        // reset settings: unity gains but nothing enabled, so silence
        queue_frame({8{SAMPLE_MAX}}, '1);
        queue_frame({8{16'h5A5A}}, '1);

        // spare indexes must not disturb anything; enable value carries stray bits
        for (int a = REG_ENABLE + 1; a < 2**CFG_ADDR_W; a++)
            queue_cfg(CFG_ADDR_W'(a), CFG_DATA_W'($urandom));
        queue_cfg(REG_ENABLE, 16'hABCF);

        queue_frame({8{SAMPLE_MAX}}, '1);
        queue_frame({8{SAMPLE_MIN}}, '1);
        // one source at the exact bounds: no clip
        queue_frame({{(SAMPLES_W-2*SAMPLE_W){1'b0}}, SAMPLE_MIN, SAMPLE_MAX}, 4'b0001);
        queue_frame({8{SAMPLE_MAX}}, 4'b0000);
        queue_frame({8{16'h5555}}, 4'b0101);
        queue_frame({8{16'hAAAA}}, 4'b1010);
        queue_frame({8{16'hFFFF}}, 4'b1111);

        // uneven gains, source 2 disabled
        queue_gains(16'hFFFF, 16'h0000, 16'h0001, 16'h1001);
        queue_cfg(REG_ENABLE, 16'h000B);
        queue_frame({8{16'hFFFF}}, '1);
        queue_frame({8{SAMPLE_MAX}}, '1);
        queue_frame({8{SAMPLE_MIN}}, '1);
        queue_frame({{(SAMPLES_W-2*SAMPLE_W){1'b0}}, 16'hFFFF, 16'h0001}, 4'b0001);
        queue_frame({8{16'h0008}}, 4'b0110);
        queue_frame({{(SAMPLES_W-2*SAMPLE_W){1'b0}}, SAMPLE_MAX, SAMPLE_MIN}, 4'b0001);

        // random phases: full gain, zero gain, then random settings, the last with no source enabled
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       queue_gains('1, '1, '1, '1);
                1:       queue_gains('0, '0, '0, '0);
                default: queue_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
            endcase
            if (p == PHASES - 1)
                queue_cfg(REG_ENABLE, '0);
            else if (p < 3)
                queue_cfg(REG_ENABLE, 16'hFFFF);
            else
                queue_cfg(REG_ENABLE, CFG_DATA_W'($urandom));
            for (int n = 0; n < PHASE_BEATS; n++) begin
                for (int s = 0; s < 2 * MAX_SOURCES; s++)
                    samples[s*SAMPLE_W +: SAMPLE_W] = rand_sample();
                present = ($urandom_range(0, 1) == 0) ? '1 : MASK_W'($urandom);
                queue_frame(samples, present);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid || expected_mix.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // every offered frame must have come back
        if (mismatch_count == 0 && expected_mix.size() == 0 && mixes_seen == beats_sent)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // driver: offers frames, applies settings only once the mixer has drained
    always @(posedge i_clk) begin : driver
        logic                  nxt_valid;
        logic [S_TDATA_W-1:0]  nxt_data;
        logic                  nxt_we;
        logic [CFG_ADDR_W-1:0] nxt_addr;
        logic [CFG_DATA_W-1:0] nxt_wdata;
        t_stim_op              op;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        nxt_we    = 1'b0;
        nxt_addr  = i_cfg_addr;
        nxt_wdata = i_cfg_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            for (int k = 0; k < MAX_SOURCES; k++)
                gain_copy[k] = GAIN_UNITY;
            enable_copy = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_mix.push_back(mix_frame(s_axis_tdata));
                beats_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending.size() != 0) begin
                op = pending[0];
                if (op.kind == OP_CFG) begin
                    if (expected_mix.size() == 0) begin
                        void'(pending.pop_front());
                        nxt_we    = 1'b1;
                        nxt_addr  = op.addr;
                        nxt_wdata = op.wdata;
                        if (op.addr < REG_ENABLE)
                            gain_copy[op.addr[GAIN_SEL_W-1:0]] = op.wdata;
                        else if (op.addr == REG_ENABLE)
                            enable_copy = op.wdata[MASK_W-1:0];
                    end
                end else if ((beats_sent >= BUSY_FIRST && beats_sent < BUSY_LAST)
                             || $urandom_range(0, 99) >= 9) begin
                    void'(pending.pop_front());
                    nxt_valid = 1'b1;
                    nxt_data  = op.beat;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
        i_cfg_we      <= nxt_we;
        i_cfg_addr    <= nxt_addr;
        i_cfg_data    <= nxt_wdata;
    end

    // monitor: checks each mixed beat and throttles the output side
    always @(posedge i_clk) begin : monitor
        t_mix_result got;
        t_mix_result want;
        logic        nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[M_RAW_W-1:0];
                mixes_seen++;
                if (expected_mix.size() == 0) begin
                    $error("mixed beat with nothing expected: right %h left %h clipped %b",
                           got.right, got.left, got.clipped);
                    mismatch_count++;
                end else begin
                    want = expected_mix.pop_front();
                    if (got.right !== want.right) begin
                        $error("right_out: expected %h, got %h", want.right, got.right);
                        mismatch_count++;
                    end
                    if (got.left !== want.left) begin
                        $error("left_out: expected %h, got %h", want.left, got.left);
                        mismatch_count++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("clipped: expected %b, got %b", want.clipped, got.clipped);
                        mismatch_count++;
                    end
                end
            end
            // one long hold-off so the input side backs up
            if (hold_left > 0) begin
                hold_left--;
            end else if (mixes_seen >= HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end else if (mixes_seen >= BUSY_FIRST && mixes_seen < BUSY_LAST) begin
                nxt_ready = 1'b1;
            end else begin
                nxt_ready = ($urandom_range(0, 99) >= 9);
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // watchdog: too long without any beat or register write
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
